/* sv/assert_macros.svh */
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DPQ_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/dpq_pkg.sv */
// Package for the deadline priority queue: sizes, codes, item and control types.
`default_nettype none

package dpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int OCC_W       = 5;
	localparam int DL_W        = 16;
	localparam int ID_W        = 16;
	localparam int FUNC_W      = 2;

	// Operation codes; code 3 returns an empty result and leaves the queue untouched
	localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
	localparam logic [FUNC_W-1:0] FN_POP    = 2'd1;
	localparam logic [FUNC_W-1:0] FN_DELETE = 2'd2;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [DL_W-1:0]   deadline;
		logic [ID_W-1:0]   target_id;
	} request_t;

	typedef struct packed {
		status_t          status;
		logic [ID_W-1:0]  task_id;
		logic [DL_W-1:0]  task_deadline;
		logic [OCC_W-1:0] occupancy;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	// Controller to datapath
	typedef struct packed {
		logic    load;      // latch request, rewind walk position
		logic    step;      // advance walk position
		logic    ins;       // insert at walk position
		logic    rem;       // remove at walk position
		logic    fail;      // result with fail_code and zero payload
		status_t fail_code;
		logic    load_out;  // move result into output register
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              empty;
		logic              full;
		logic              at_end;  // walk position equals entry count
		logic              match;   // entry at walk position meets the search
	} dp_sts_t;

endpackage

`default_nettype wire

/* sv/dpq_datapath.sv */
// Datapath: sorted entry store with per-entry shift, walk position, result and output registers.
`default_nettype none

module dpq_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dpq_pkg::request_t request,
	input  wire dpq_pkg::dp_cmd_t  cmd,
	output dpq_pkg::dp_sts_t       sts,
	output dpq_pkg::result_t       result
);

	localparam int DEPTH = dpq_pkg::QUEUE_DEPTH;

	logic [dpq_pkg::DL_W-1:0] dl_q [DEPTH];
	logic [dpq_pkg::ID_W-1:0] id_q [DEPTH];
	logic [dpq_pkg::DL_W-1:0] lo_dl [DEPTH];
	logic [dpq_pkg::ID_W-1:0] lo_id [DEPTH];
	logic [dpq_pkg::DL_W-1:0] hi_dl [DEPTH];
	logic [dpq_pkg::ID_W-1:0] hi_id [DEPTH];

	logic [dpq_pkg::CNT_W-1:0]  count_q;
	logic [dpq_pkg::CNT_W-1:0]  pos_q;
	logic [dpq_pkg::ID_W-1:0]   next_id_q;
	logic [dpq_pkg::FUNC_W-1:0] func_q;
	logic [dpq_pkg::DL_W-1:0]   req_dl_q;
	logic [dpq_pkg::ID_W-1:0]   req_tid_q;
	dpq_pkg::status_t           res_status_q;
	logic [dpq_pkg::ID_W-1:0]   res_id_q;
	logic [dpq_pkg::DL_W-1:0]   res_dl_q;
	dpq_pkg::result_t           out_q;

	logic [dpq_pkg::DL_W-1:0] cur_dl;
	logic [dpq_pkg::ID_W-1:0] cur_id;

	// Neighbor taps for the shift: lower neighbor on insert, upper on remove
	for (genvar g = 0; g < DEPTH; g++) begin : g_taps
		if (g == 0) begin : g_first
			assign lo_dl[g] = dl_q[g];
			assign lo_id[g] = id_q[g];
		end else begin : g_rest
			assign lo_dl[g] = dl_q[g-1];
			assign lo_id[g] = id_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign hi_dl[g] = dl_q[g];
			assign hi_id[g] = id_q[g];
		end else begin : g_body
			assign hi_dl[g] = dl_q[g+1];
			assign hi_id[g] = id_q[g+1];
		end
	end

	// Entry at the walk position
	assign cur_dl = dl_q[pos_q[dpq_pkg::IDX_W-1:0]];
	assign cur_id = id_q[pos_q[dpq_pkg::IDX_W-1:0]];

	// Status toward the controller
	always_comb begin
		sts.func   = func_q;
		sts.empty  = (count_q == '0);
		sts.full   = (count_q == dpq_pkg::CNT_W'(DEPTH));
		sts.at_end = (pos_q == count_q);
		sts.match  = (func_q == dpq_pkg::FN_INSERT) ? (cur_dl >= req_dl_q)
		                                           : (cur_id == req_tid_q);
	end

	// Entry store: each entry loads from a neighbor or the new task
	always_ff @(posedge clk) begin
		for (int i = 0; i < DEPTH; i++) begin
			if (cmd.ins) begin
				if (pos_q == dpq_pkg::CNT_W'(i)) begin
					dl_q[i] <= req_dl_q;
					id_q[i] <= next_id_q;
				end else if (pos_q < dpq_pkg::CNT_W'(i)) begin
					dl_q[i] <= lo_dl[i];
					id_q[i] <= lo_id[i];
				end
			end else if (cmd.rem) begin
				if (pos_q <= dpq_pkg::CNT_W'(i)) begin
					dl_q[i] <= hi_dl[i];
					id_q[i] <= hi_id[i];
				end
			end
		end
	end

	// Latched request fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q    <= request.func;
			req_dl_q  <= request.deadline;
			req_tid_q <= request.target_id;
		end
	end

	// Count, id counter and walk position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_id_q <= dpq_pkg::ID_W'(1);
			pos_q     <= '0;
		end else begin
			if (cmd.ins) begin
				count_q   <= count_q + 1'b1;
				next_id_q <= next_id_q + 1'b1;
			end else if (cmd.rem) begin
				count_q <= count_q - 1'b1;
			end
			if (cmd.load) begin
				pos_q <= '0;
			end else if (cmd.step) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	// Result of the current item
	always_ff @(posedge clk) begin
		if (cmd.ins) begin
			res_status_q <= dpq_pkg::ST_OK;
			res_id_q     <= next_id_q;
			res_dl_q     <= req_dl_q;
		end else if (cmd.rem) begin
			res_status_q <= dpq_pkg::ST_OK;
			res_id_q     <= cur_id;
			res_dl_q     <= cur_dl;
		end else if (cmd.fail) begin
			res_status_q <= cmd.fail_code;
			res_id_q     <= '0;
			res_dl_q     <= '0;
		end
	end

	// Output register, occupancy taken after the update
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.status        <= res_status_q;
			out_q.task_id       <= res_id_q;
			out_q.task_deadline <= res_dl_q;
			out_q.occupancy     <= dpq_pkg::OCC_W'(count_q);
		end
	end

	assign result = out_q;

endmodule

`default_nettype wire

/* sv/dpq_ctrl.sv */
// Controller: state machine that sequences the entry walk and the result handoff.
`default_nettype none

module dpq_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             request_valid,
	output logic                  request_stall,
	output logic                  result_valid,
	input  wire logic             result_stall,
	input  wire dpq_pkg::dp_sts_t sts,
	output dpq_pkg::dp_cmd_t      cmd
);

	dpq_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            out_free;

	assign out_free      = !out_valid_q || !result_stall;
	assign request_stall = (state_q != dpq_pkg::S_IDLE);
	assign result_valid  = out_valid_q;

	// State register and output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dpq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.fail_code = dpq_pkg::ST_OK;
		case (state_q)
			dpq_pkg::S_IDLE: begin
				if (request_valid) begin
					cmd.load = 1'b1;
					state_d  = dpq_pkg::S_SCAN;
				end
			end
			dpq_pkg::S_SCAN: begin
				state_d = dpq_pkg::S_DONE;
				case (sts.func)
					dpq_pkg::FN_INSERT: begin
						if (sts.full) begin
							cmd.fail      = 1'b1;
							cmd.fail_code = dpq_pkg::ST_FULL;
						end else if (sts.at_end || sts.match) begin
							cmd.ins = 1'b1;
						end else begin
							cmd.step = 1'b1;
							state_d  = dpq_pkg::S_SCAN;
						end
					end
					dpq_pkg::FN_POP: begin
						if (sts.empty) begin
							cmd.fail      = 1'b1;
							cmd.fail_code = dpq_pkg::ST_EMPTY;
						end else begin
							cmd.rem = 1'b1;
						end
					end
					dpq_pkg::FN_DELETE: begin
						if (sts.empty) begin
							cmd.fail      = 1'b1;
							cmd.fail_code = dpq_pkg::ST_EMPTY;
						end else if (sts.at_end) begin
							cmd.fail      = 1'b1;
							cmd.fail_code = dpq_pkg::ST_NOT_FOUND;
						end else if (sts.match) begin
							cmd.rem = 1'b1;
						end else begin
							cmd.step = 1'b1;
							state_d  = dpq_pkg::S_SCAN;
						end
					end
					default: begin
						// unused code: empty result, queue untouched
						cmd.fail = 1'b1;
					end
				endcase
			end
			dpq_pkg::S_DONE: begin
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = dpq_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = dpq_pkg::S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

/* sv/deadline_priority_queue.sv */
// Flow: an accepted item is latched, walks k stored entries in the scan state, then moves to the
// output register in the done state once that is free (k is 0 for pop, up to QUEUE_DEPTH-1 for
// insert, QUEUE_DEPTH for delete). One item at a time is handled; the walk compares one stored
// entry per cycle. A waiting result does not block acceptance of the next item.
// Reset: count cleared, next task id set to 1; the entry store is not cleared.
// Top level: deadline-ordered task queue with insert, pop earliest and delete by id.
`default_nettype none

module deadline_priority_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              request_valid,
	output logic                   request_stall,
	input  wire dpq_pkg::request_t request,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output dpq_pkg::result_t       result
);

	dpq_pkg::dp_cmd_t cmd;
	dpq_pkg::dp_sts_t sts;

	dpq_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.sts           (sts),
		.cmd           (cmd)
	);

	dpq_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.sts     (sts),
		.result  (result)
	);

endmodule

`default_nettype wire

/* sv/dpq_checker.sv */
// Port-level checker for the deadline priority queue, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dpq_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              request_valid,
	input wire logic              request_stall,
	input wire dpq_pkg::request_t request,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire dpq_pkg::result_t  result
);

	// A stalled result holds
	`DPQ_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && result_stall, result_valid && $stable(result), "stalled result changed")

	// One item in flight: the next cycle after acceptance stalls
	`DPQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, request_valid && !request_stall, request_stall, "item accepted while busy")

	// A full report comes with a full queue and no task
	`DPQ_ASSERT_SAME(a_full_occ, clk, arst_n, result_valid && result.status == dpq_pkg::ST_FULL, result.occupancy == dpq_pkg::OCC_W'(dpq_pkg::QUEUE_DEPTH) && result.task_id == '0, "full status with wrong occupancy")

	// An empty report comes with an empty queue and no task
	`DPQ_ASSERT_SAME(a_empty_occ, clk, arst_n, result_valid && result.status == dpq_pkg::ST_EMPTY, result.occupancy == '0 && result.task_id == '0 && result.task_deadline == '0, "empty status with content")

endmodule

bind deadline_priority_queue dpq_checker u_dpq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.request_valid (request_valid),
	.request_stall (request_stall),
	.request       (request),
	.result_valid  (result_valid),
	.result_stall  (result_stall),
	.result        (result)
);

`default_nettype wire
